FILE: rtl/akht_pkg.sv
package akht_pkg;

    // Table geometry; TABLE_SLOTS must be a power of two (16 .. 65536)
    localparam int TABLE_SLOTS = 1024;
    localparam int IDX_W       = $clog2(TABLE_SLOTS);
    localparam int CNT_W       = IDX_W + 1;
    localparam int HOME_SHIFT  = 4;

    localparam int KEY_W = 48;
    localparam int VAL_W = 32;
    localparam int STS_W = 2;

    localparam logic [STS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STS_W-1:0] STATUS_ZERO_KEY = 2'd2;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_INSERT = 1'b1;

    localparam logic [CNT_W-1:0] HALF_SLOTS = CNT_W'(TABLE_SLOTS / 2);
    localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(TABLE_SLOTS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX   = IDX_W'(TABLE_SLOTS - 1);

    typedef struct packed {
        logic             kind;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [VAL_W-1:0] found_value;
        logic             hit;
        logic [STS_W-1:0] status;
    } t_out_word;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_slot;

    // controller -> datapath
    typedef struct packed {
        logic clr_en;
        logic accept;
        logic check;
        logic load_out;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic zero_key;
        logic probe_done;
    } t_dp_sts;

endpackage

FILE: rtl/address_keyed_hash_table.sv
// Sequence: a zero key goes from accept straight to finish and the result word;
// otherwise read, then check across the P slots probed (one registered memory read per slot).
// One word in flight; the next is taken once the result moves to the output register.
// Reset (synchronous): a clearing pass writes every slot (TABLE_SLOTS, 1024) with
// input stalled; the occupancy count and output valid clear at once.
module address_keyed_hash_table import akht_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    akht_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    akht_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

FILE: rtl/akht_datapath.sv
module akht_datapath import akht_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_data,
    input  t_dp_cmd   i_cmd,
    output t_dp_sts   o_sts,
    output t_out_word o_out_data
);

    t_slot r_mem [TABLE_SLOTS];
    t_slot r_rd;

    logic             r_kind;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_steps;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_clr;
    t_out_word        r_res;
    t_out_word        r_out;

    logic             match, empty, last, full;
    logic             wr_item, ins_new;
    logic             w_en;
    logic [IDX_W-1:0] w_addr;
    logic [IDX_W-1:0] rd_addr;
    t_slot            w_data;
    t_out_word        n_res;

    assign match   = (r_rd.key == r_key);
    assign empty   = (r_rd.key == '0);
    assign last    = (r_steps == LAST_STEP);
    assign full    = (r_count >= HALF_SLOTS);

    assign wr_item = (r_kind == KIND_INSERT) && (match || (empty && !full));
    assign ins_new = (r_kind == KIND_INSERT) && !match && empty && !full;

    // while checking, the next slot is read ahead so a miss moves on at once
    assign rd_addr = i_cmd.check ? r_idx + 1'b1 : r_idx;
    assign w_en    = i_cmd.clr_en || (i_cmd.check && wr_item);
    assign w_addr  = i_cmd.clr_en ? r_clr : r_idx;
    assign w_data  = i_cmd.clr_en ? t_slot'('0) : t_slot'({r_key, r_value});

    always_comb begin
        n_res.found_value = (r_kind == KIND_LOOKUP && match) ? r_rd.value : '0;
        n_res.hit         = match;
        n_res.status      = (r_kind == KIND_INSERT && !match && (full || !empty))
                            ? STATUS_FULL : STATUS_OK;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_clr   <= '0;
        end else begin
            if (i_cmd.clr_en) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cmd.check && ins_new) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind             <= i_in_data.kind;
            r_key              <= i_in_data.key;
            r_value            <= i_in_data.value;
            r_idx              <= i_in_data.key[HOME_SHIFT +: IDX_W];
            r_steps            <= '0;
            r_res.found_value  <= '0;
            r_res.hit          <= 1'b0;
            r_res.status       <= STATUS_ZERO_KEY;
        end else if (i_cmd.check) begin
            if (o_sts.probe_done) begin
                r_res <= n_res;
            end else begin
                r_idx   <= r_idx + 1'b1;
                r_steps <= r_steps + 1'b1;
            end
        end
        if (i_cmd.load_out) begin
            r_out <= r_res;
        end
    end

    assign o_sts.clr_last   = (r_clr == LAST_IDX);
    assign o_sts.zero_key   = (i_in_data.key == '0);
    assign o_sts.probe_done = match || empty || last;
    assign o_out_data       = r_out;

endmodule

FILE: rtl/akht_ctrl.sv
module akht_ctrl import akht_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_CHECK,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd.clr_en   = (r_state == S_CLEAR);
        o_cmd.accept   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.check    = (r_state == S_CHECK);
        o_cmd.load_out = (r_state == S_FINISH) && out_free;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_in_valid) r_state <= i_sts.zero_key ? S_FINISH : S_READ;
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (i_sts.probe_done) r_state <= S_FINISH;
                end
                S_FINISH: begin
                    if (out_free) r_state <= S_IDLE;
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

endmodule

FILE: rtl/akht_checker.sv
module akht_checker import akht_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_word  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_data
);

    // a stalled result word stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result word dropped while stalled");

    // one word at a time: input stalls right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second word accepted while one in flight");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == STATUS_OK ||
                         o_out_data.status == STATUS_FULL ||
                         o_out_data.status == STATUS_ZERO_KEY))
        else $error("undefined status code");

    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |-> o_out_data.status == STATUS_OK)
        else $error("hit with refusal status");

    a_refusal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != STATUS_OK
        |-> !o_out_data.hit && o_out_data.found_value == '0)
        else $error("refused word carries data");

endmodule

bind address_keyed_hash_table akht_checker u_akht_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
